// ===== hdl/sorted_key_table_with_cursor_defines.svh =====
// assertion macros used by the checker file
`ifndef SORTED_KEY_TABLE_WITH_CURSOR_DEFINES_SVH
`define SORTED_KEY_TABLE_WITH_CURSOR_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SKT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/skt_pkg.sv =====
package skt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // item field widths
  localparam int KEY_W = 10;
  localparam int PL_W  = 16;
  localparam int OP_W  = 3;

  // operation codes
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_INSERT    = 3'd0;
  localparam op_t OP_REMOVE    = 3'd1;
  localparam op_t OP_LOOKUP    = 3'd2;
  localparam op_t OP_STEP_UP   = 3'd3;
  localparam op_t OP_STEP_DOWN = 3'd4;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // what every cell does with its entry this cycle
  typedef enum logic [3:0] {
    MODE_HOLD     = 4'b0001,
    MODE_INSERT   = 4'b0010,
    MODE_REMOVE   = 4'b0100,
    MODE_WRITE_PL = 4'b1000
  } cell_mode_t;

  // command broadcast along the cell row
  typedef struct packed {
    logic              cmp;
    cell_mode_t        mode;
    logic              rd_cursor;
    logic [KEY_W-1:0]  key;
    logic [PL_W-1:0]   payload;
  } cell_cmd_t;

endpackage

// ===== hdl/sorted_key_table_with_cursor.sv =====
// Sorted key table with a cursor, kept in a row of cells, one entry per cell.
// Input channel (in_valid/in_ready) carries op, key and payload; output
// channel (out_valid/out_ready) carries status, out_key, out_payload,
// cursor_pos and entry_total, one result per accepted item.
// Ops: insert (or payload rewrite of an existing key), remove, lookup
// (moves the cursor), step up and step down (cursor wraps at both ends).
// Each item runs through compare, execute and output steps: all cells
// compare against the key at once, then the row shifts or rewrites while the
// selected entry is read out, then the result is held in output registers.
// out_valid rises once the compare and execute states (S_CMP, S_EXEC) that
// follow the input transfer are done. The per-cell compare and the neighbor
// shift keep the work per item independent of the table fill.
// One item is in flight at a time: in_ready is high only while idle, so a
// stalled receiver holds the result and the input side waits with it.
// Reset (rst, synchronous, active high) empties the table and sets the
// cursor to zero; entry contents are not cleared.
module sorted_key_table_with_cursor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [skt_pkg::OP_W-1:0]    op,
  input  logic [skt_pkg::KEY_W-1:0]   key,
  input  logic [skt_pkg::PL_W-1:0]    payload,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [skt_pkg::KEY_W-1:0]   out_key,
  output logic [skt_pkg::PL_W-1:0]    out_payload,
  output logic [skt_pkg::IDX_W-1:0]   cursor_pos,
  output logic [skt_pkg::CNT_W-1:0]   entry_total
);

  localparam int DEPTH = skt_pkg::TABLE_DEPTH;
  localparam int IDX_W = skt_pkg::IDX_W;
  localparam int CNT_W = skt_pkg::CNT_W;
  localparam int KEY_W = skt_pkg::KEY_W;
  localparam int PL_W  = skt_pkg::PL_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_EXEC = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;

  logic [skt_pkg::OP_W-1:0] op_q;
  logic [KEY_W-1:0]         key_q;
  logic [PL_W-1:0]          payload_q;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         cursor;
  skt_pkg::status_t         status_q;
  logic [KEY_W-1:0]         out_key_q;
  logic [PL_W-1:0]          out_payload_q;

  skt_pkg::cell_cmd_t       cmd;
  skt_pkg::cell_mode_t      mode_next;
  skt_pkg::status_t         status_next;
  logic [KEY_W-1:0]         out_key_next;
  logic [PL_W-1:0]          out_payload_next;
  logic [CNT_W-1:0]         count_next;
  logic [IDX_W-1:0]         cursor_next;

  logic [DEPTH-1:0]         hi_v;
  logic [DEPTH-1:0]         eq_v;
  logic [DEPTH-1:0]         valid_v;
  logic [DEPTH-1:0]         cur_hit_v;
  logic [DEPTH-1:0]         left_hi_v;
  logic [KEY_W-1:0]         ent_key_v     [DEPTH];
  logic [PL_W-1:0]          ent_payload_v [DEPTH];
  logic [KEY_W-1:0]         left_key_v    [DEPTH];
  logic [PL_W-1:0]          left_pl_v     [DEPTH];
  logic [KEY_W-1:0]         right_key_v   [DEPTH];
  logic [PL_W-1:0]          right_pl_v    [DEPTH];
  logic [KEY_W-1:0]         rd_key_v      [DEPTH];
  logic [PL_W-1:0]          rd_pl_v       [DEPTH];

  logic [KEY_W-1:0]         rd_key;
  logic [PL_W-1:0]          rd_payload;
  logic [IDX_W-1:0]         hit_idx;
  logic                     found;
  logic                     is_step;
  logic [CNT_W-1:0]         cnt_last;
  logic [CNT_W-1:0]         cnt_dec;
  logic [CNT_W-1:0]         cnt_dec_last;
  logic [CNT_W-1:0]         cursor_ext;
  logic [IDX_W-1:0]         step_cursor;

  // handshake
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // cell row with neighbor links
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign valid_v[i]   = (CNT_W'(i) < count);
    assign cur_hit_v[i] = (cursor == IDX_W'(i));

    if (i == 0) begin : g_first
      assign left_hi_v[i]  = 1'b0;
      assign left_key_v[i] = '0;
      assign left_pl_v[i]  = '0;
    end else begin : g_mid
      assign left_hi_v[i]  = hi_v[i-1];
      assign left_key_v[i] = ent_key_v[i-1];
      assign left_pl_v[i]  = ent_payload_v[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key_v[i] = ent_key_v[i];
      assign right_pl_v[i]  = ent_payload_v[i];
    end else begin : g_inner
      assign right_key_v[i] = ent_key_v[i+1];
      assign right_pl_v[i]  = ent_payload_v[i+1];
    end

    skt_cell u_cell (
      .clk           (clk),
      .cmd           (cmd),
      .valid         (valid_v[i]),
      .cur_hit       (cur_hit_v[i]),
      .left_hi       (left_hi_v[i]),
      .left_key      (left_key_v[i]),
      .left_payload  (left_pl_v[i]),
      .right_key     (right_key_v[i]),
      .right_payload (right_pl_v[i]),
      .hi            (hi_v[i]),
      .eq            (eq_v[i]),
      .ent_key       (ent_key_v[i]),
      .ent_payload   (ent_payload_v[i]),
      .rd_key        (rd_key_v[i]),
      .rd_payload    (rd_pl_v[i])
    );
  end

  // merge the selected entry and encode the matching index (at most one match)
  always_comb begin
    rd_key     = '0;
    rd_payload = '0;
    hit_idx    = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_key     = rd_key | rd_key_v[i];
      rd_payload = rd_payload | rd_pl_v[i];
      hit_idx    = hit_idx | (eq_v[i] ? IDX_W'(i) : '0);
    end
  end

  assign found   = |eq_v;
  assign is_step = (op_q == skt_pkg::OP_STEP_UP) || (op_q == skt_pkg::OP_STEP_DOWN);

  // cursor arithmetic
  assign cursor_ext   = CNT_W'(cursor);
  assign cnt_last     = count - CNT_W'(1);
  assign cnt_dec      = count - CNT_W'(1);
  assign cnt_dec_last = count - CNT_W'(2);

  always_comb begin
    if (op_q == skt_pkg::OP_STEP_UP) begin
      step_cursor = (cursor_ext >= cnt_last) ? '0 : cursor + IDX_W'(1);
    end else begin
      step_cursor = (cursor == '0 || cursor_ext >= count) ? cnt_last[IDX_W-1:0]
                                                          : cursor - IDX_W'(1);
    end
  end

  // result and row command for the execute cycle
  always_comb begin
    mode_next        = skt_pkg::MODE_HOLD;
    status_next      = skt_pkg::ST_OK;
    out_key_next     = '0;
    out_payload_next = '0;
    count_next       = count;
    cursor_next      = cursor;
    case (op_q)
      skt_pkg::OP_INSERT: begin
        if (found) begin
          mode_next        = skt_pkg::MODE_WRITE_PL;
          out_key_next     = key_q;
          out_payload_next = payload_q;
        end else if (count >= CNT_W'(DEPTH)) begin
          status_next  = skt_pkg::ST_FULL;
          out_key_next = key_q;
        end else begin
          mode_next        = skt_pkg::MODE_INSERT;
          count_next       = count + CNT_W'(1);
          out_key_next     = key_q;
          out_payload_next = payload_q;
        end
      end
      skt_pkg::OP_REMOVE: begin
        if (found) begin
          mode_next        = skt_pkg::MODE_REMOVE;
          count_next       = cnt_dec;
          out_key_next     = rd_key;
          out_payload_next = rd_payload;
          if (cnt_dec == '0) begin
            cursor_next = '0;
          end else if (cursor_ext >= cnt_dec) begin
            cursor_next = cnt_dec_last[IDX_W-1:0];
          end
        end else begin
          status_next  = skt_pkg::ST_NOT_FOUND;
          out_key_next = key_q;
        end
      end
      skt_pkg::OP_LOOKUP: begin
        if (found) begin
          cursor_next      = hit_idx;
          out_key_next     = rd_key;
          out_payload_next = rd_payload;
        end else begin
          status_next  = skt_pkg::ST_NOT_FOUND;
          out_key_next = key_q;
        end
      end
      skt_pkg::OP_STEP_UP, skt_pkg::OP_STEP_DOWN: begin
        if (count == '0) begin
          status_next = skt_pkg::ST_EMPTY;
          cursor_next = '0;
        end else begin
          out_key_next     = rd_key;
          out_payload_next = rd_payload;
        end
      end
      default: begin
      end
    endcase
  end

  // broadcast to the cell row
  always_comb begin
    cmd           = '0;
    cmd.cmp       = (state == S_CMP);
    cmd.mode      = (state == S_EXEC) ? mode_next : skt_pkg::MODE_HOLD;
    cmd.rd_cursor = is_step;
    cmd.key       = key_q;
    cmd.payload   = payload_q;
  end

  // sequencer and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      cursor <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (is_step && count != '0) begin
            cursor <= step_cursor;
          end
          state <= S_EXEC;
        end
        S_EXEC: begin
          count  <= count_next;
          cursor <= cursor_next;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item capture and result registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q      <= op;
      key_q     <= key;
      payload_q <= payload;
    end
    if (state == S_EXEC) begin
      status_q      <= status_next;
      out_key_q     <= out_key_next;
      out_payload_q <= out_payload_next;
    end
  end

  assign status      = status_q;
  assign out_key     = out_key_q;
  assign out_payload = out_payload_q;
  assign cursor_pos  = cursor;
  assign entry_total = count;

endmodule

// ===== hdl/skt_cell.sv =====
module skt_cell (
  input  logic                        clk,
  input  skt_pkg::cell_cmd_t          cmd,
  input  logic                        valid,
  input  logic                        cur_hit,
  input  logic                        left_hi,
  input  logic [skt_pkg::KEY_W-1:0]   left_key,
  input  logic [skt_pkg::PL_W-1:0]    left_payload,
  input  logic [skt_pkg::KEY_W-1:0]   right_key,
  input  logic [skt_pkg::PL_W-1:0]    right_payload,
  output logic                        hi,
  output logic                        eq,
  output logic [skt_pkg::KEY_W-1:0]   ent_key,
  output logic [skt_pkg::PL_W-1:0]    ent_payload,
  output logic [skt_pkg::KEY_W-1:0]   rd_key,
  output logic [skt_pkg::PL_W-1:0]    rd_payload
);

  logic sel;

  // compare flags: hi marks the entry at or above the search key, or unused
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      eq <= valid && (ent_key == cmd.key);
      hi <= !valid || (ent_key >= cmd.key);
    end
  end

  // entry update: open a gap, close a gap, or rewrite the payload
  always_ff @(posedge clk) begin
    case (cmd.mode)
      skt_pkg::MODE_INSERT: begin
        if (hi) begin
          if (left_hi) begin
            ent_key     <= left_key;
            ent_payload <= left_payload;
          end else begin
            ent_key     <= cmd.key;
            ent_payload <= cmd.payload;
          end
        end
      end
      skt_pkg::MODE_REMOVE: begin
        if (hi) begin
          ent_key     <= right_key;
          ent_payload <= right_payload;
        end
      end
      skt_pkg::MODE_WRITE_PL: begin
        if (eq) begin
          ent_payload <= cmd.payload;
        end
      end
      default: begin
      end
    endcase
  end

  // read contribution, zero unless this cell is selected
  assign sel        = cmd.rd_cursor ? cur_hit : eq;
  assign rd_key     = sel ? ent_key : '0;
  assign rd_payload = sel ? ent_payload : '0;

endmodule

// ===== hdl/skt_checker.sv =====
`include "sorted_key_table_with_cursor_defines.svh"

module skt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  status,
  input logic [skt_pkg::KEY_W-1:0]   out_key,
  input logic [skt_pkg::PL_W-1:0]    out_payload,
  input logic [skt_pkg::IDX_W-1:0]   cursor_pos,
  input logic [skt_pkg::CNT_W-1:0]   entry_total
);

  // fill never exceeds the table
  `SKT_ASSERT_NOW(a_fill_bound, 1'b1,
    entry_total <= skt_pkg::CNT_W'(skt_pkg::TABLE_DEPTH),
    "entry_total beyond table depth")

  // a full report only comes from a full table
  `SKT_ASSERT_NOW(a_full_consistent, out_valid && status == skt_pkg::ST_FULL,
    entry_total == skt_pkg::CNT_W'(skt_pkg::TABLE_DEPTH),
    "full status with free entries")

  // cursor points at a live entry, or at zero when empty
  `SKT_ASSERT_NOW(a_cursor_range, out_valid,
    (entry_total == '0) ? (cursor_pos == '0)
                        : (skt_pkg::CNT_W'(cursor_pos) < entry_total),
    "cursor outside the filled range")

  // an empty report comes with an empty table and zero data
  `SKT_ASSERT_NOW(a_empty_consistent, out_valid && status == skt_pkg::ST_EMPTY,
    entry_total == '0 && out_key == '0 && out_payload == '0,
    "empty status with entries or data")

  // a stalled result holds
  `SKT_ASSERT_NEXT(a_result_hold, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(out_key) && $stable(out_payload),
    "result changed while stalled")

endmodule

bind sorted_key_table_with_cursor skt_checker u_skt_checker (.*);
